[src/nso_pkg.sv]
// Shared types, constants and tables for the separation offset block.
`default_nettype none
package nso_pkg;

    localparam int SPACING_BITS = 23;
    localparam int OUT_BITS     = 24;
    localparam int DIR_BITS     = 18;

    localparam logic [SPACING_BITS-1:0] SPACING_RESET = 23'd5243;
    localparam logic [63:0] POS_LIM = 64'd1 << SPACING_BITS;

    localparam logic [63:0] MIX_C1 = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_C2 = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_C3 = 64'h94D0_49BB_1331_11EB;
    localparam logic [31:0] PAIR_K1 = 32'h85EB_CA6B;
    localparam logic [31:0] PAIR_K2 = 32'hC2B2_AE35;
    localparam logic [31:0] PAIR_K3 = 32'h27D4_EB2F;

    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_MSQX, S_MSQY, S_MSP, S_CHK, S_SQRT, S_DIVX, S_DIVY,
        S_PM1, S_PM2, S_H1, S_H2, S_CORD, S_STR, S_MULX, S_MULY, S_FIN,
        S_LSQX, S_LSQY, S_LSP, S_LCHK, S_LSQRT, S_LMX, S_LDX, S_LMY, S_LDY,
        S_EMIT
    } st_t;

    // Arctangent per step, 2^32 phase units per turn.
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] r;
        unique case (idx)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[src/neighbor_separation_offset.sv]
// Top level: neighbor separation offset sequencer and its serial units.
// Per neighbor the path depends on the case: skipped, out of range, close, or an exact overlap,
// through the serial multiplier, divider, square root and CORDIC units as the case needs them.
// One item is in work at a time; the last item adds a final pass, with the clamp to the spacing
// when the sum exceeds it, and a hashed direction first on a cancelled sum.
// Reset (aresetn low, synchronous) clears sums, close flag, state, output valid, spacing 5243.
`default_nettype none
module neighbor_separation_offset #(
    parameter int POSITION_BITS = 24,
    parameter int CORDIC_STEPS  = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [nso_pkg::SPACING_BITS-1:0]   cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [31:0]                        s_self_id,
    input  wire logic signed [POSITION_BITS-1:0]    s_self_x,
    input  wire logic signed [POSITION_BITS-1:0]    s_self_y,
    input  wire logic [31:0]                        s_neighbor_id,
    input  wire logic signed [POSITION_BITS-1:0]    s_neighbor_x,
    input  wire logic signed [POSITION_BITS-1:0]    s_neighbor_y,
    input  wire logic                               s_neighbor_valid,
    input  wire logic                               s_last_neighbor,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [nso_pkg::OUT_BITS-1:0]     m_offset_x,
    output logic signed [nso_pkg::OUT_BITS-1:0]     m_offset_y,
    output logic                                    m_any_close
);
    import nso_pkg::*;

    localparam int DW = POSITION_BITS + 1;

    st_t state_reg, state_next;

    logic [SPACING_BITS-1:0] sp_reg;
    logic [31:0]             sid_reg, sid_next, nid_reg, nid_next;
    logic                    nval_reg, nval_next, last_reg, last_next;
    logic signed [DW-1:0]    dx_reg, dx_next, dy_reg, dy_next;
    logic [63:0]             d2_reg, d2_next, sp2_reg, sp2_next, hx_reg, hx_next;
    logic [31:0]             dist_reg, dist_next, t_reg, t_next;
    logic [16:0]             str_reg, str_next;
    logic signed [32:0]      vx_reg, vx_next, vy_reg, vy_next;
    logic signed [31:0]      sum_x_reg, sum_x_next, sum_y_reg, sum_y_next;
    logic                    close_reg, close_next, neg_reg, neg_next;
    logic                    fin_reg, fin_next, go_reg, go_next;
    logic                    mv_reg, mv_next, mac_reg, mac_next;
    logic signed [OUT_BITS-1:0] mox_reg, mox_next, moy_reg, moy_next;

    logic        mul_start, mul_busy, div_start, div_busy;
    logic        sq_start, sq_busy, cor_start, cor_busy;
    logic [63:0] mul_a, mul_b, mul_p, div_num, div_q, sq_v;
    logic [31:0] div_den, sq_root, cor_phase, mix;
    logic signed [DIR_BITS-1:0] cor_c, cor_s;

    logic [DW-1:0] adx, ady;
    logic [32:0]   avx, avy;
    logic [63:0]   rnd;
    logic          proc, op_ok;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] s,
                                                   input logic neg,
                                                   input logic [31:0] m);
        logic signed [33:0] r;
        r = $signed({s[31], s[31], s});
        r = neg ? (r - $signed({2'b00, m})) : (r + $signed({2'b00, m}));
        if (r > 34'sd2147483647)       return 32'sh7FFF_FFFF;
        else if (r < -34'sd2147483648) return 32'sh8000_0000;
        else                           return r[31:0];
    endfunction

    nso_mul u_mul (.aclk, .aresetn, .start(mul_start), .a(mul_a), .b(mul_b),
                   .busy(mul_busy), .p(mul_p));
    nso_div u_div (.aclk, .aresetn, .start(div_start), .num(div_num), .den(div_den),
                   .busy(div_busy), .q(div_q));
    nso_sqrt u_sqrt (.aclk, .aresetn, .start(sq_start), .v(sq_v),
                     .busy(sq_busy), .root(sq_root));
    nso_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk, .aresetn, .start(cor_start), .phase(cor_phase), .busy(cor_busy),
        .cos_q(cor_c), .sin_q(cor_s));

    assign adx  = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
    assign ady  = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
    assign avx  = vx_reg[32] ? 33'(-vx_reg) : 33'(vx_reg);
    assign avy  = vy_reg[32] ? 33'(-vy_reg) : 33'(vy_reg);
    assign proc = nval_reg && (nid_reg != sid_reg) &&
                  (64'(adx) < POS_LIM) && (64'(ady) < POS_LIM);
    assign rnd  = (mul_p + 64'd32768) >> 16;
    assign mix  = t_reg + mul_p[31:0] + PAIR_K3;
    assign cor_phase = hx_reg[31:0] ^ hx_reg[62:31];

    // Operation finished: the unit was launched and has gone quiet.
    always_comb begin
        unique case (state_reg)
            S_SQRT, S_LSQRT:                      op_ok = go_reg && !sq_busy;
            S_DIVX, S_DIVY, S_STR, S_LDX, S_LDY:  op_ok = go_reg && !div_busy;
            S_CORD:                               op_ok = go_reg && !cor_busy;
            default:                              op_ok = go_reg && !mul_busy;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_DEC;
            S_DEC:   state_next = proc ? S_MSQX : (last_reg ? S_FIN : S_IDLE);
            S_MSQX:  if (op_ok) state_next = S_MSQY;
            S_MSQY:  if (op_ok) state_next = S_MSP;
            S_MSP:   if (op_ok) state_next = S_CHK;
            S_CHK: begin
                if (d2_reg < sp2_reg) state_next = (d2_reg == '0) ? S_PM1 : S_SQRT;
                else                  state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_SQRT:  if (op_ok) state_next = S_DIVX;
            S_DIVX:  if (op_ok) state_next = S_DIVY;
            S_DIVY:  if (op_ok) state_next = S_STR;
            S_PM1:   if (op_ok) state_next = S_PM2;
            S_PM2:   if (op_ok) state_next = S_H1;
            S_H1:    if (op_ok) state_next = S_H2;
            S_H2:    if (op_ok) state_next = S_CORD;
            S_CORD:  if (op_ok) state_next = fin_reg ? S_LSQX : S_STR;
            S_STR:   if (op_ok) state_next = S_MULX;
            S_MULX:  if (op_ok) state_next = S_MULY;
            S_MULY:  if (op_ok) state_next = last_reg ? S_FIN : S_IDLE;
            S_FIN: begin
                if (close_reg && sum_x_reg == '0 && sum_y_reg == '0) state_next = S_H1;
                else                                                state_next = S_LSQX;
            end
            S_LSQX:  if (op_ok) state_next = S_LSQY;
            S_LSQY:  if (op_ok) state_next = S_LSP;
            S_LSP:   if (op_ok) state_next = S_LCHK;
            S_LCHK:  state_next = (d2_reg > sp2_reg) ? S_LSQRT : S_EMIT;
            S_LSQRT: if (op_ok) state_next = S_LMX;
            S_LMX:   if (op_ok) state_next = S_LDX;
            S_LDX:   if (op_ok) state_next = S_LMY;
            S_LMY:   if (op_ok) state_next = S_LDY;
            S_LDY:   if (op_ok) state_next = S_EMIT;
            S_EMIT:  if (!mv_reg || m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        sid_next = sid_reg;   nid_next = nid_reg;
        nval_next = nval_reg; last_next = last_reg;
        dx_next = dx_reg;     dy_next = dy_reg;
        d2_next = d2_reg;     sp2_next = sp2_reg;   hx_next = hx_reg;
        dist_next = dist_reg; t_next = t_reg;       str_next = str_reg;
        vx_next = vx_reg;     vy_next = vy_reg;
        sum_x_next = sum_x_reg; sum_y_next = sum_y_reg;
        close_next = close_reg; neg_next = neg_reg; fin_next = fin_reg;
        go_next = go_reg;
        mv_next = mv_reg && !m_ready;
        mac_next = mac_reg;   mox_next = mox_reg;   moy_next = moy_reg;
        s_ready = 1'b0;
        mul_start = 1'b0; div_start = 1'b0; sq_start = 1'b0; cor_start = 1'b0;
        mul_a = '0; mul_b = '0; div_num = '0; div_den = '0; sq_v = '0;

        // Launch the unit once on entry, then wait for it.
        unique case (state_reg)
            S_MSQX, S_MSQY, S_MSP, S_PM1, S_PM2, S_H1, S_H2, S_MULX, S_MULY,
            S_LSQX, S_LSQY, S_LSP, S_LMX, S_LMY: begin
                mul_start = !go_reg;
            end
            S_SQRT, S_LSQRT:                     sq_start  = !go_reg;
            S_DIVX, S_DIVY, S_STR, S_LDX, S_LDY: div_start = !go_reg;
            S_CORD:                              cor_start = !go_reg;
            default: ;
        endcase
        if (mul_start || sq_start || div_start || cor_start) go_next = 1'b1;
        if (op_ok) go_next = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    sid_next  = s_self_id;
                    nid_next  = s_neighbor_id;
                    nval_next = s_neighbor_valid;
                    last_next = s_last_neighbor;
                    dx_next   = {s_self_x[POSITION_BITS-1], s_self_x}
                              - {s_neighbor_x[POSITION_BITS-1], s_neighbor_x};
                    dy_next   = {s_self_y[POSITION_BITS-1], s_self_y}
                              - {s_neighbor_y[POSITION_BITS-1], s_neighbor_y};
                    fin_next  = 1'b0;
                    go_next   = 1'b0;
                end
            end
            S_MSQX: begin
                mul_a = 64'(adx); mul_b = 64'(adx);
                if (op_ok) d2_next = mul_p;
            end
            S_MSQY: begin
                mul_a = 64'(ady); mul_b = 64'(ady);
                if (op_ok) d2_next = d2_reg + mul_p;
            end
            S_MSP, S_LSP: begin
                mul_a = 64'(sp_reg); mul_b = 64'(sp_reg);
                if (op_ok) sp2_next = mul_p;
            end
            S_CHK: begin
                if (d2_reg < sp2_reg) begin
                    close_next = 1'b1;
                    neg_next   = sid_reg > nid_reg;
                    dist_next  = '0;
                end
            end
            S_SQRT: begin
                sq_v = d2_reg;
                if (op_ok) dist_next = sq_root;
            end
            S_DIVX: begin
                div_num = 64'(adx) << 16; div_den = dist_reg;
                if (op_ok) vx_next = dx_reg[DW-1] ? -$signed({1'b0, div_q[31:0]})
                                                  : $signed({1'b0, div_q[31:0]});
            end
            S_DIVY: begin
                div_num = 64'(ady) << 16; div_den = dist_reg;
                if (op_ok) vy_next = dy_reg[DW-1] ? -$signed({1'b0, div_q[31:0]})
                                                  : $signed({1'b0, div_q[31:0]});
            end
            S_PM1: begin
                mul_a = 64'((sid_reg < nid_reg) ? sid_reg : nid_reg);
                mul_b = 64'(PAIR_K1);
                if (op_ok) t_next = mul_p[31:0];
            end
            S_PM2: begin
                mul_a = 64'((sid_reg < nid_reg) ? nid_reg : sid_reg);
                mul_b = 64'(PAIR_K2);
                if (op_ok) hx_next = 64'(mix) + MIX_C1;
            end
            S_H1: begin
                mul_a = hx_reg ^ (hx_reg >> 30); mul_b = MIX_C2;
                if (op_ok) hx_next = mul_p;
            end
            S_H2: begin
                mul_a = hx_reg ^ (hx_reg >> 27); mul_b = MIX_C3;
                if (op_ok) hx_next = mul_p;
            end
            S_CORD: begin
                if (op_ok) begin
                    if (neg_reg && !fin_reg) begin
                        vx_next = -33'(cor_c);
                        vy_next = -33'(cor_s);
                    end else begin
                        vx_next = 33'(cor_c);
                        vy_next = 33'(cor_s);
                    end
                end
            end
            S_STR: begin
                div_num = 64'(sp_reg - dist_reg[SPACING_BITS-1:0]) << 16;
                div_den = 32'(sp_reg);
                if (op_ok) str_next = div_q[16:0];
            end
            S_MULX: begin
                mul_a = 64'(avx); mul_b = 64'(str_reg);
                if (op_ok) sum_x_next = sat_add(sum_x_reg, vx_reg[32], rnd[31:0]);
            end
            S_MULY: begin
                mul_a = 64'(avy); mul_b = 64'(str_reg);
                if (op_ok) sum_y_next = sat_add(sum_y_reg, vy_reg[32], rnd[31:0]);
            end
            S_FIN: begin
                fin_next = 1'b1;
                go_next  = 1'b0;
                if (close_reg && sum_x_reg == '0 && sum_y_reg == '0) begin
                    hx_next = {32'd0, sid_reg} + MIX_C1;
                end else begin
                    vx_next = 33'(sum_x_reg);
                    vy_next = 33'(sum_y_reg);
                end
            end
            S_LSQX: begin
                mul_a = 64'(avx); mul_b = 64'(avx);
                if (op_ok) d2_next = mul_p;
            end
            S_LSQY: begin
                mul_a = 64'(avy); mul_b = 64'(avy);
                if (op_ok) d2_next = d2_reg + mul_p;
            end
            S_LSQRT: begin
                sq_v = d2_reg;
                if (op_ok) dist_next = sq_root;
            end
            S_LMX: begin
                mul_a = 64'(avx); mul_b = 64'(sp_reg);
                if (op_ok) hx_next = mul_p;
            end
            S_LDX: begin
                div_num = hx_reg; div_den = dist_reg;
                if (op_ok) vx_next = vx_reg[32] ? -$signed({1'b0, div_q[31:0]})
                                                : $signed({1'b0, div_q[31:0]});
            end
            S_LMY: begin
                mul_a = 64'(avy); mul_b = 64'(sp_reg);
                if (op_ok) hx_next = mul_p;
            end
            S_LDY: begin
                div_num = hx_reg; div_den = dist_reg;
                if (op_ok) vy_next = vy_reg[32] ? -$signed({1'b0, div_q[31:0]})
                                                : $signed({1'b0, div_q[31:0]});
            end
            S_EMIT: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    mox_next   = vx_reg[OUT_BITS-1:0];
                    moy_next   = vy_reg[OUT_BITS-1:0];
                    mac_next   = close_reg;
                    sum_x_next = '0;
                    sum_y_next = '0;
                    close_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sp_reg    <= SPACING_RESET;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            close_reg <= 1'b0;
            go_reg    <= 1'b0;
            fin_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) sp_reg <= cfg_wdata;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            close_reg <= close_next;
            go_reg    <= go_next;
            fin_reg   <= fin_next;
            mv_reg    <= mv_next;
        end
        sid_reg  <= sid_next;  nid_reg  <= nid_next;
        nval_reg <= nval_next; last_reg <= last_next;
        dx_reg   <= dx_next;   dy_reg   <= dy_next;
        d2_reg   <= d2_next;   sp2_reg  <= sp2_next;  hx_reg <= hx_next;
        dist_reg <= dist_next; t_reg    <= t_next;    str_reg <= str_next;
        vx_reg   <= vx_next;   vy_reg   <= vy_next;   neg_reg <= neg_next;
        mac_reg  <= mac_next;  mox_reg  <= mox_next;  moy_reg <= moy_next;
    end

    assign m_valid     = mv_reg;
    assign m_offset_x  = mox_reg;
    assign m_offset_y  = moy_reg;
    assign m_any_close = mac_reg;

`ifndef SYNTHESIS
    a_far_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_any_close |-> m_offset_x == '0 && m_offset_y == '0)
        else $error("offset nonzero without a close neighbor");
    a_sum_needs_close: assert property (@(posedge aclk) disable iff (!aresetn)
        !close_reg |-> sum_x_reg == '0 && sum_y_reg == '0)
        else $error("sum moved without a close neighbor");
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_DEC)
        else $error("transfer did not start work");
    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !go_reg)
        else $error("input ready while a unit is launched");
`endif
endmodule
`default_nettype wire

[src/nso_mul.sv]
// Bit-serial shift-add multiplier, low 64 bits of the product.
`default_nettype none
module nso_mul (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             busy,
    output logic [63:0]      p
);
    logic [63:0] a_reg, a_next, b_reg, b_next, p_reg, p_next;
    logic        busy_reg, busy_next;

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        p_next    = p_reg;
        busy_next = busy_reg;
        if (start) begin
            a_next    = a;
            b_next    = b;
            p_next    = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (b_reg == '0) begin
                busy_next = 1'b0;
            end else begin
                if (b_reg[0]) p_next = p_reg + a_reg;
                a_next = {a_reg[62:0], 1'b0};
                b_next = {1'b0, b_reg[63:1]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) busy_reg <= 1'b0;
        else          busy_reg <= busy_next;
        a_reg <= a_next;
        b_reg <= b_next;
        p_reg <= p_next;
    end

    assign busy = busy_reg;
    assign p    = p_reg;
endmodule
`default_nettype wire

[src/nso_div.sv]
// Restoring divider, one quotient bit per cycle, 64 by 32 bits.
`default_nettype none
module nso_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [31:0] den,
    output logic             busy,
    output logic [63:0]      q
);
    logic [63:0] q_reg, q_next;
    logic [31:0] r_reg, r_next, d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] sh;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        sh        = {r_reg, q_reg[63]};
        if (start) begin
            q_next    = num;
            r_next    = '0;
            d_next    = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (sh >= {1'b0, d_reg}) begin
                r_next = 32'(sh - {1'b0, d_reg});
                q_next = {q_reg[62:0], 1'b1};
            end else begin
                r_next = sh[31:0];
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) busy_reg <= 1'b0;
        else          busy_reg <= busy_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        cnt_reg <= cnt_next;
    end

    assign busy = busy_reg;
    assign q    = q_reg;
endmodule
`default_nettype wire

[src/nso_sqrt.sv]
// Digit-by-digit integer square root, one root bit per cycle.
`default_nettype none
module nso_sqrt (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] v,
    output logic             busy,
    output logic [31:0]      root
);
    logic [63:0] v_reg, v_next;
    logic [31:0] rt_reg, rt_next;
    logic [33:0] rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [33:0] cur, trial;

    always_comb begin
        v_next    = v_reg;
        rt_next   = rt_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        cur       = {rem_reg[31:0], v_reg[63:62]};
        trial     = {rt_reg, 2'b01};
        if (start) begin
            v_next    = v;
            rt_next   = '0;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (cur >= trial) begin
                rem_next = cur - trial;
                rt_next  = {rt_reg[30:0], 1'b1};
            end else begin
                rem_next = cur;
                rt_next  = {rt_reg[30:0], 1'b0};
            end
            v_next   = {v_reg[61:0], 2'b00};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) busy_reg <= 1'b0;
        else          busy_reg <= busy_next;
        v_reg   <= v_next;
        rt_reg  <= rt_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

    assign busy = busy_reg;
    assign root = rt_reg;
endmodule
`default_nettype wire

[src/nso_cordic.sv]
// Iterative rotation CORDIC: phase to Q.16 cosine and sine.
`default_nettype none
module nso_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                start,
    input  wire logic [31:0]                         phase,
    output logic                                     busy,
    output logic signed [nso_pkg::DIR_BITS-1:0]      cos_q,
    output logic signed [nso_pkg::DIR_BITS-1:0]      sin_q
);
    import nso_pkg::*;

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    logic signed [33:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [IW-1:0]      i_reg, i_next;
    logic               flip_reg, flip_next, busy_reg, busy_next;
    logic [31:0]        p_plus, p_adj;
    logic signed [33:0] xs, ys, at, xr, yr;
    logic signed [DIR_BITS-1:0] xc, yc;

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        flip_next = flip_reg;
        busy_next = busy_reg;
        p_plus    = phase + 32'h4000_0000;
        p_adj     = p_plus[31] ? (phase - 32'h8000_0000) : phase;
        xs        = x_reg >>> i_reg;
        ys        = y_reg >>> i_reg;
        at        = $signed({2'b00, atan_turn(5'(i_reg))});
        if (start) begin
            flip_next = p_plus[31];
            z_next    = $signed({{2{p_adj[31]}}, p_adj});
            x_next    = CORDIC_GAIN_Q30;
            y_next    = '0;
            i_next    = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!z_reg[33]) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            i_next = i_reg + 1'b1;
            if (i_reg == IW'(CORDIC_STEPS - 1)) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) busy_reg <= 1'b0;
        else          busy_reg <= busy_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        i_reg    <= i_next;
        flip_reg <= flip_next;
    end

    // Round Q.30 to Q.16, then undo the half-turn fold.
    assign xr    = (x_reg + 34'sd8192) >>> 14;
    assign yr    = (y_reg + 34'sd8192) >>> 14;
    assign xc    = xr[DIR_BITS-1:0];
    assign yc    = yr[DIR_BITS-1:0];
    assign cos_q = flip_reg ? -xc : xc;
    assign sin_q = flip_reg ? -yc : yc;
    assign busy  = busy_reg;
endmodule
`default_nettype wire
